/* rtl/hspd_pkg.sv */
// ----------------------------------------------------------------------------
// hspd_pkg
// Shared types and constants for the humidity sensor pulse decoder.
// ----------------------------------------------------------------------------
package hspd_pkg;

    localparam int WIDTH_W    = 8;
    localparam int FIELD_W    = 16;
    localparam int FRAME_W    = 40;
    localparam int BITCNT_W   = 6;
    localparam int WINDOW_W   = 3;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [BITCNT_W-1:0] DATA_BITS = 6'd40;

    // input item codes
    localparam logic MODE_PULSE = 1'b0;
    localparam logic MODE_END   = 1'b1;

    // sign-magnitude temperature byte
    localparam logic [7:0] SIGN_MASK = 8'h80;
    localparam logic [7:0] MAG_MASK  = 8'h7f;

    // register reset values
    localparam logic [7:0]          ZERO_BORDER_RST   = 8'd100;
    localparam logic [7:0]          START_MIN_LEN_RST = 8'd150;
    localparam logic [WINDOW_W-1:0] START_WINDOW_RST  = 3'd4;
    localparam logic                NARROW_FORMAT_RST = 1'b0;

    typedef enum logic [1:0] {
        REG_ZERO_BORDER   = 2'd0,
        REG_START_MIN_LEN = 2'd1,
        REG_START_WINDOW  = 2'd2,
        REG_NARROW_FORMAT = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_START = 2'd1,
        ST_SHORT    = 2'd2,
        ST_CHECKSUM = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]          zero_border;
        logic [7:0]          start_min_len;
        logic [WINDOW_W-1:0] start_window;
        logic                narrow_format;
    } cfg_t;

    typedef struct packed {
        logic [FIELD_W-1:0]        humidity;
        logic signed [FIELD_W-1:0] temperature;
        status_t                   status;
    } result_t;

endpackage

/* rtl/hspd_if.sv */
// ----------------------------------------------------------------------------
// hspd_if
// Valid/ready channels for pulse items and decoded results.
// ----------------------------------------------------------------------------
interface hspd_in_if import hspd_pkg::*;;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [WIDTH_W-1:0] pulse_width;

    modport source (output valid, output mode, output pulse_width, input ready);
    modport sink   (input valid, input mode, input pulse_width, output ready);
endinterface

interface hspd_out_if import hspd_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [FIELD_W-1:0]        humidity;
    logic signed [FIELD_W-1:0] temperature;
    logic [1:0]                status;

    modport source (output valid, output humidity, output temperature, output status,
                    input ready);
    modport sink   (input valid, input humidity, input temperature, input status,
                    output ready);
endinterface

/* rtl/hspd_regs.sv */
// ----------------------------------------------------------------------------
// hspd_regs
// APB register file holding the decoder thresholds and output format.
// ----------------------------------------------------------------------------
module hspd_regs import hspd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_ZERO_BORDER:   cfg_next.zero_border   = pwdata[7:0];
                REG_START_MIN_LEN: cfg_next.start_min_len = pwdata[7:0];
                REG_START_WINDOW:  cfg_next.start_window  = pwdata[WINDOW_W-1:0];
                REG_NARROW_FORMAT: cfg_next.narrow_format = pwdata[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_border   <= ZERO_BORDER_RST;
            cfg_reg.start_min_len <= START_MIN_LEN_RST;
            cfg_reg.start_window  <= START_WINDOW_RST;
            cfg_reg.narrow_format <= NARROW_FORMAT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ZERO_BORDER:   prdata = {24'd0, cfg_reg.zero_border};
            REG_START_MIN_LEN: prdata = {24'd0, cfg_reg.start_min_len};
            REG_START_WINDOW:  prdata = {29'd0, cfg_reg.start_window};
            REG_NARROW_FORMAT: prdata = {31'd0, cfg_reg.narrow_format};
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/hspd_frame.sv */
// ----------------------------------------------------------------------------
// hspd_frame
// Capture state: start pulse search, 40-bit data shift, frame decode.
// ----------------------------------------------------------------------------
module hspd_frame import hspd_pkg::*;
#(
    parameter int MAX_CAPTURES = 45
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_go,
    input  logic               item_mode,
    input  logic [WIDTH_W-1:0] item_width,
    input  cfg_t               cfg,
    output result_t            result
);

    localparam int CAP_W = $clog2(MAX_CAPTURES + 1);
    localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(MAX_CAPTURES);

    logic [CAP_W-1:0]    capture_index_reg, capture_index_next;
    logic                start_found_reg, start_found_next;
    logic [BITCNT_W-1:0] bit_count_reg, bit_count_next;
    logic [FRAME_W-1:0]  bit_shift_reg, bit_shift_next;

    logic [7:0]          b0, b1, b2, b3, b4;
    logic [7:0]          sum8;
    logic [14:0]         mag;
    logic [FIELD_W-1:0]  mag16;

    // state update for one item
    always_comb
    begin
        capture_index_next = capture_index_reg;
        start_found_next   = start_found_reg;
        bit_count_next     = bit_count_reg;
        bit_shift_next     = bit_shift_reg;
        if (item_go)
        begin
            if (item_mode == MODE_END)
            begin
                capture_index_next = '0;
                start_found_next   = 1'b0;
                bit_count_next     = '0;
                bit_shift_next     = '0;
            end
            else if (capture_index_reg < CAP_LIMIT)
            begin
                capture_index_next = capture_index_reg + 1'b1;
                if (!start_found_reg)
                begin
                    if ((capture_index_reg < CAP_W'(cfg.start_window)) &&
                        (item_width > cfg.start_min_len))
                        start_found_next = 1'b1;
                end
                else if (bit_count_reg < DATA_BITS)
                begin
                    bit_shift_next = {bit_shift_reg[FRAME_W-2:0],
                                      (item_width > cfg.zero_border)};
                    bit_count_next = bit_count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capture_index_reg <= '0;
            start_found_reg   <= 1'b0;
            bit_count_reg     <= '0;
            bit_shift_reg     <= '0;
        end
        else
        begin
            capture_index_reg <= capture_index_next;
            start_found_reg   <= start_found_next;
            bit_count_reg     <= bit_count_next;
            bit_shift_reg     <= bit_shift_next;
        end
    end

    // frame decode from the current state
    assign b0    = bit_shift_reg[39:32];
    assign b1    = bit_shift_reg[31:24];
    assign b2    = bit_shift_reg[23:16];
    assign b3    = bit_shift_reg[15:8];
    assign b4    = bit_shift_reg[7:0];
    assign sum8  = 8'(b0 + b1 + b2 + b3);
    assign mag   = cfg.narrow_format ? {8'd0, b2[6:0] & MAG_MASK[6:0]}
                                     : {b2[6:0] & MAG_MASK[6:0], b3};
    assign mag16 = {1'b0, mag};

    always_comb
    begin
        result.humidity    = '0;
        result.temperature = '0;
        priority if (!start_found_reg)
            result.status = ST_NO_START;
        else if (bit_count_reg < DATA_BITS)
            result.status = ST_SHORT;
        else if (sum8 != b4)
            result.status = ST_CHECKSUM;
        else
        begin
            result.status      = ST_OK;
            result.humidity    = cfg.narrow_format ? {8'd0, b0} : {b0, b1};
            result.temperature = ((b2 & SIGN_MASK) != 8'd0) ? FIELD_W'(~mag16 + 1'b1)
                                                            : mag16;
        end
    end

endmodule

/* rtl/humidity_sensor_pulse_decoder_top.sv */
// ----------------------------------------------------------------------------
// humidity_sensor_pulse_decoder_top
// Decodes a single-wire humidity/temperature sensor frame from pulse widths.
// ----------------------------------------------------------------------------
// Usage:
//   din carries one beat per captured edge-to-edge width (mode 0) and one
//   end-of-capture beat (mode 1) per frame. Only the first MAX_CAPTURES widths
//   of a capture count; the first width above start_min_len inside the first
//   start_window widths is the start pulse, the next 40 widths are data bits.
//   dout carries one beat per end-of-capture beat: humidity, two's complement
//   temperature and a status (ok, no start, too few bits, checksum mismatch).
//   Thresholds and the DHT22/DHT11 layout sit in APB registers at 0x0..0xC.
// Timing:
//   One beat per cycle on din unless an end beat is held for a stalled dout.
//   A beat lands in an input register and from there updates the capture
//   state; an end beat loads the result register in that same cycle, and
//   the result register drives dout.
//   Frame decode (checksum add, sign fix) is one short layer of logic.
// Reset / stall:
//   rst_n clears capture state and restores register defaults; nothing to
//   sweep afterwards. While dout is stalled, width beats keep flowing; an end
//   beat waits in the input register until the result register frees up.
// ----------------------------------------------------------------------------
module humidity_sensor_pulse_decoder_top import hspd_pkg::*;
#(
    parameter int MAX_CAPTURES = 45
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    hspd_in_if.sink               din,
    hspd_out_if.source            dout,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t               cfg;
    result_t            frame_result;

    // input stage
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_mode_reg;
    logic [WIDTH_W-1:0] s1_width_reg;
    logic               s1_go;
    logic               din_fire;

    // result stage
    logic               out_valid_reg, out_valid_next;
    result_t            out_data_reg;
    logic               out_load;

    hspd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Width beats never need the result register; end beats only move
    // when it is empty or being drained this cycle.
    assign s1_go    = s1_valid_reg &&
                      ((s1_mode_reg == MODE_PULSE) || !out_valid_reg || dout.ready);
    assign din.ready = !s1_valid_reg || s1_go;
    assign din_fire = din.valid && din.ready;
    assign out_load = s1_go && (s1_mode_reg == MODE_END);

    hspd_frame #(
        .MAX_CAPTURES (MAX_CAPTURES)
    ) u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_go    (s1_go),
        .item_mode  (s1_mode_reg),
        .item_width (s1_width_reg),
        .cfg        (cfg),
        .result     (frame_result)
    );

    always_comb
    begin
        s1_valid_next = din_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
        out_valid_next = out_load ? 1'b1 : (dout.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (din_fire)
        begin
            s1_mode_reg  <= din.mode;
            s1_width_reg <= din.pulse_width;
        end
        if (out_load)
            out_data_reg <= frame_result;
    end

    assign dout.valid       = out_valid_reg;
    assign dout.humidity    = out_data_reg.humidity;
    assign dout.temperature = out_data_reg.temperature;
    assign dout.status      = out_data_reg.status;

`ifndef NO_ASSERTIONS
    // an end beat leaving the input stage always shows up on dout next cycle
    a_end_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> dout.valid)
        else $error("end beat did not produce a result");

    // a stalled result must block an end beat in the input stage
    a_end_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_mode_reg == MODE_END) && out_valid_reg && !dout.ready)
        |-> !s1_go)
        else $error("end beat overwrote a pending result");

    // error results carry zero fields
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && (dout.status != ST_OK))
        |-> ((dout.humidity == '0) && (dout.temperature == '0)))
        else $error("error result with nonzero fields");

    // back-pressure on din only comes from a held input stage
    a_ready_src: assert property (@(posedge clk) disable iff (!rst_n)
        !din.ready |-> (s1_valid_reg && out_valid_reg && !dout.ready))
        else $error("din stalled without cause");
`endif

endmodule

/* tb/sv/tb_humidity_sensor_pulse_decoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_humidity_sensor_pulse_decoder_top
// Self-checking bench for the single-wire sensor frame decoder.
// Pulse-width and end-of-capture beats go in on din. A local copy of the
// decode logic predicts each reading, and dout is checked against it in order.
// The APB registers are rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_humidity_sensor_pulse_decoder_top;
    import hspd_pkg::*;

    localparam int CAPTURE_LIMIT = 45;

    // ------------------------------------------------------------------
    // Clock, reset, APB and channel signals
    // ------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    hspd_in_if  din_if ();
    hspd_out_if dout_if ();

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    humidity_sensor_pulse_decoder_top #(
        .MAX_CAPTURES (CAPTURE_LIMIT)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din_if),
        .dout    (dout_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Decoder copy: register shadow plus capture state
    // ------------------------------------------------------------------
    cfg_t              model_cfg;
    int                cap_count;     // widths counted, stops at CAPTURE_LIMIT
    bit                start_seen;
    int                data_bits;     // data bits collected, at most FRAME_W
    logic [FRAME_W-1:0] frame_shift;

    result_t           readings_due[$];  // readings still owed by dout

    int                mismatches;
    int                readings_seen;
    int                beats_accepted;
    bit                gaps_on;
    int                burst_left;

    // Applies one accepted din beat to the decoder copy. An end beat turns
    // the collected frame into a reading and clears the capture.
    task automatic advance_capture(input logic mode, input logic [WIDTH_W-1:0] width);
        int          pos;
        result_t     reading;
        logic [7:0]  b0, b1, b2, b3, b4, sum;
        logic [15:0] mag;
        if (mode == MODE_PULSE)
        begin
            if (cap_count < CAPTURE_LIMIT)
            begin
                pos = cap_count;
                cap_count++;
                if (!start_seen)
                begin
                    if (pos < model_cfg.start_window && width > model_cfg.start_min_len)
                        start_seen = 1'b1;
                end
                else if (data_bits < FRAME_W)
                begin
                    frame_shift = {frame_shift[FRAME_W-2:0], width > model_cfg.zero_border};
                    data_bits++;
                end
            end
        end
        else
        begin
            reading = '0;
            if (!start_seen)
                reading.status = ST_NO_START;
            else if (data_bits < FRAME_W)
                reading.status = ST_SHORT;
            else
            begin
                {b0, b1, b2, b3, b4} = frame_shift;
                sum = b0 + b1 + b2 + b3;
                if (sum != b4)
                    reading.status = ST_CHECKSUM;
                else
                begin
                    reading.status = ST_OK;
                    if (model_cfg.narrow_format)
                    begin
                        reading.humidity = {8'h00, b0};
                        mag = {8'h00, b2 & MAG_MASK};
                    end
                    else
                    begin
                        reading.humidity = {b0, b1};
                        mag = {b2 & MAG_MASK, b3};
                    end
                    // sign-magnitude to two's complement
                    reading.temperature = ((b2 & SIGN_MASK) != 0) ? -mag : mag;
                end
            end
            readings_due.push_back(reading);
            cap_count   = 0;
            start_seen  = 1'b0;
            data_bits   = 0;
            frame_shift = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One din beat. Bursts of random length with random idle gaps between
    // them when gaps_on is set. valid stays high across back-to-back beats.
    task automatic send_beat(input logic mode, input logic [WIDTH_W-1:0] width);
        if (gaps_on && burst_left == 0)
        begin
            din_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        din_if.valid       <= 1'b1;
        din_if.mode        <= mode;
        din_if.pulse_width <= width;
        @(posedge clk);
        while (!din_if.ready)
            @(posedge clk);
        advance_capture(mode, width);
        beats_accepted++;
        @(negedge clk);
    endtask

    task automatic din_idle();
        din_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Wait for every owed reading, then idle longer so trailing width beats
    // have left the input register before registers change.
    task automatic drain();
        din_idle();
        while (readings_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle; lands when pready is high.
    task automatic write_reg(input reg_idx_t idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h000000, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_ZERO_BORDER:   model_cfg.zero_border   = value;
            REG_START_MIN_LEN: model_cfg.start_min_len = value;
            REG_START_WINDOW:  model_cfg.start_window  = value[WINDOW_W-1:0];
            REG_NARROW_FORMAT: model_cfg.narrow_format = value[0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(input logic [7:0] zb, input logic [7:0] sml,
                                  input logic [7:0] win, input logic [7:0] narrow);
        drain();
        write_reg(REG_ZERO_BORDER, zb);
        write_reg(REG_START_MIN_LEN, sml);
        write_reg(REG_START_WINDOW, win);
        write_reg(REG_NARROW_FORMAT, narrow);
    endtask

    // Five sensor bytes, byte 4 the checksum, optionally spoiled.
    function automatic logic [FRAME_W-1:0] pack_frame(input logic [7:0] b0, input logic [7:0] b1,
                                                       input logic [7:0] b2, input logic [7:0] b3,
                                                       input bit corrupt);
        logic [7:0] sum;
        sum = b0 + b1 + b2 + b3;
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        return {b0, b1, b2, b3, sum};
    endfunction

    // Width that encodes one data bit under the current zero_border. extreme
    // pins ones to 255 and zeros to 0. With zero_border at 255 no width reads
    // as a one, so 255 goes out and the copy decodes it as zero.
    function automatic logic [WIDTH_W-1:0] width_for_bit(input bit one, input bit extreme);
        int zb;
        zb = model_cfg.zero_border;
        if (one)
            return (extreme || zb == 255) ? 8'd255 : 8'($urandom_range(zb + 1, 255));
        return extreme ? 8'd0 : 8'($urandom_range(0, zb));
    endfunction

    // Lead-in widths below the start threshold, the start pulse, data_n data
    // bits MSB first, trailing widths, then the end-of-capture beat.
    task automatic send_frame(input logic [FRAME_W-1:0] bits, input int lead, input int data_n,
                              input int extras, input bit extreme);
        int sml;
        sml = model_cfg.start_min_len;
        repeat (lead)
            send_beat(MODE_PULSE, extreme ? 8'd0 : 8'($urandom_range(0, sml)));
        send_beat(MODE_PULSE, (extreme || sml == 255) ? 8'd255 : 8'($urandom_range(sml + 1, 255)));
        for (int i = 0; i < data_n; i++)
            send_beat(MODE_PULSE, width_for_bit(bits[FRAME_W-1-i], extreme));
        repeat (extras)
            send_beat(MODE_PULSE, 8'($urandom));
        send_beat(MODE_END, 8'($urandom));
    endtask

    // Mostly well-formed frames with random bytes; the rest truncated,
    // overrun past the capture limit, or plain noise.
    task automatic send_random_frame();
        int               kind;
        int               lead;
        int               win;
        logic [FRAME_W-1:0] bits;
        win  = model_cfg.start_window;
        lead = (win > 0) ? $urandom_range(0, win - 1) : $urandom_range(0, 2);
        bits = pack_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          $urandom_range(0, 7) == 0);
        kind = $urandom_range(0, 9);
        case (kind)
            7: send_frame(bits, lead, $urandom_range(0, FRAME_W - 1), $urandom_range(0, 2), 1'b0);
            8:
            begin
                repeat ($urandom_range(0, 50))
                    send_beat(MODE_PULSE, 8'($urandom));
                send_beat(MODE_END, 8'($urandom));
            end
            9: send_frame(bits, lead, FRAME_W, $urandom_range(3, 12), 1'b0);
            default: send_frame(bits, lead, FRAME_W, $urandom_range(0, 3), 1'b0);
        endcase
    endtask

    task automatic run_random(input int n_beats);
        int first;
        first = beats_accepted;
        while (beats_accepted - first < n_beats)
            send_random_frame();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults: empty capture, start out of window, short frame and a
    // full negative-temperature frame with widths at 0/255 that runs past
    // the capture limit.
    task automatic test_directed_cases();
        logic [FRAME_W-1:0] bits;
        gaps_on = 1'b0;
        send_beat(MODE_END, 8'hff);
        // threshold itself is not a start; 255 lands one past the window
        send_beat(MODE_PULSE, START_MIN_LEN_RST);
        send_beat(MODE_PULSE, 8'd0);
        send_beat(MODE_PULSE, START_MIN_LEN_RST);
        send_beat(MODE_PULSE, START_MIN_LEN_RST);
        send_beat(MODE_PULSE, 8'd255);
        send_beat(MODE_END, 8'h00);
        bits = pack_frame(8'h02, 8'h8c, 8'h80 | 8'h01, 8'h65, 1'b0);
        send_frame(bits, 1, 5, 0, 1'b1);
        // 1 lead + start + 40 data + 4 extras = 46 widths, last one dropped
        gaps_on = 1'b1;
        send_frame(bits, 1, FRAME_W, 4, 1'b1);
    endtask

    task automatic test_wide_format();
        apply_settings(8'($urandom_range(60, 140)), 8'($urandom_range(141, 230)), 8'd4, 8'd0);
        gaps_on = 1'b1;
        run_random(200);
    endtask

    task automatic test_narrow_format();
        apply_settings(8'($urandom_range(30, 120)), 8'($urandom_range(100, 250)), 8'd3, 8'd1);
        gaps_on = 1'b0;
        run_random(150);
    endtask

    task automatic test_threshold_extremes();
        logic [FRAME_W-1:0] bits;
        // everything above zero is a one, and a start if it is the first width
        apply_settings(8'd0, 8'd0, 8'd1, 8'd1);
        gaps_on = 1'b1;
        run_random(60);
        // no width can start a frame
        apply_settings(8'd255, 8'd255, 8'd7, 8'd0);
        run_random(50);
        // zero-length start window
        apply_settings(8'd100, 8'd0, 8'd0, 8'd1);
        run_random(50);
        // ones impossible: all-zero frame, checksum still matches
        apply_settings(8'd255, 8'd0, 8'd4, 8'd0);
        run_random(50);
        // wide window: late starts leave too few counted widths
        apply_settings(8'd0, 8'd254, 8'd7, 8'd0);
        bits = pack_frame(8'h55, 8'haa, 8'h7f, 8'hff, 1'b0);
        send_frame(bits, 6, FRAME_W, 0, 1'b0);
        send_frame(bits, 5, FRAME_W, 0, 1'b0);
        send_frame(bits, 4, FRAME_W, 0, 1'b0);
        run_random(50);
    endtask

    // Random settings per phase until enough beats and readings went by.
    task automatic test_random_mix();
        logic [7:0] win;
        while (beats_accepted < 1050 || readings_seen < 48)
        begin
            win = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(1, 4));
            apply_settings(8'($urandom), 8'($urandom_range(0, 254)), win, 8'($urandom_range(0, 1)));
            gaps_on = $urandom_range(0, 2) != 0;
            run_random(100);
        end
    endtask

    // ------------------------------------------------------------------
    // dout stall pattern: a rotating 16-bit mask, reloaded every run of
    // cycles; some runs are all-ready so stall-free stretches occur too.
    // ------------------------------------------------------------------
    initial
    begin
        logic [15:0] stall_pat;
        int          run;
        dout_if.ready = 1'b0;
        stall_pat = 16'hffff;
        run = 0;
        forever
        begin
            @(negedge clk);
            if (run == 0)
            begin
                run = $urandom_range(16, 96);
                stall_pat = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
            end
            run--;
            stall_pat = {stall_pat[0], stall_pat[15:1]};
            dout_if.ready <= stall_pat[0];
        end
    end

    // ------------------------------------------------------------------
    // Reading checker: each dout beat against the oldest owed reading.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            readings_seen++;
            if (readings_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected reading hum %h temp %0d status %0d", $time,
                             dout_if.humidity, dout_if.temperature, dout_if.status);
            end
            else
            begin
                want = readings_due.pop_front();
                if (dout_if.humidity !== want.humidity ||
                    dout_if.temperature !== want.temperature ||
                    dout_if.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: reading differs: expected hum %h temp %0d status %0d, got hum %h temp %0d status %0d",
                                 $time, want.humidity, want.temperature, want.status,
                                 dout_if.humidity, dout_if.temperature, dout_if.status);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        din_if.valid       = 1'b0;
        din_if.mode        = MODE_PULSE;
        din_if.pulse_width = '0;
        model_cfg.zero_border   = ZERO_BORDER_RST;
        model_cfg.start_min_len = START_MIN_LEN_RST;
        model_cfg.start_window  = START_WINDOW_RST;
        model_cfg.narrow_format = NARROW_FORMAT_RST;
        cap_count      = 0;
        start_seen     = 1'b0;
        data_bits      = 0;
        frame_shift    = '0;
        mismatches     = 0;
        readings_seen  = 0;
        beats_accepted = 0;
        gaps_on        = 1'b0;
        burst_left     = 0;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_wide_format();
        test_narrow_format();
        test_threshold_extremes();
        test_random_mix();

        // readings still in flight, then a margin before the verdict
        din_idle();
        while (readings_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Run limit, far above the slowest legal run.
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
rtl/hspd_pkg.sv
rtl/hspd_if.sv
rtl/hspd_regs.sv
rtl/hspd_frame.sv
rtl/humidity_sensor_pulse_decoder_top.sv
tb/sv/tb_humidity_sensor_pulse_decoder_top.sv
